FILE: rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
package skt_pkg;

  // Field widths fixed by the item format
  localparam int unsigned KeyW = 32;
  localparam int unsigned PosW = 6;
  localparam int unsigned CntOutW = 7;

  // Operation codes carried on the command field
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch item and register the cell compares
    logic apply;    // shift the cells, update count, load the result
  } ctrl_t;

endpackage

FILE: rtl/sorted_key_table.sv
// Top level of the sorted key table.
//
//   channel   signals                               handshake
//   command   start, busy, command_i, key_i          taken when start && !busy
//   result    result_valid_o, success_o,             one-cycle strobe, no back-pressure
//             position_o, entry_count_o
//
// An item is captured, then applied: the capture edge registers the compare of the key
// against every cell in parallel, the next edge shifts the cells and loads the result.
// The result strobe is high the cycle after that, and a new item may start in it.
// Reset empties the table by clearing the count; the cell contents are left as they are.
// The receiver cannot stall; busy is high only during the shift cycle.
module sorted_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command_i,
  input  logic [skt_pkg::KeyW-1:0]     key_i,
  output logic                         result_valid_o,
  output logic                         success_o,
  output logic [skt_pkg::PosW-1:0]     position_o,
  output logic [skt_pkg::CntOutW-1:0]  entry_count_o
);

  skt_pkg::ctrl_t ctrl;

  skt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .ctrl_o         (ctrl),
    .result_valid_o (result_valid_o)
  );

  skt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .command_i     (command_i),
    .key_i         (key_i),
    .success_o     (success_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

endmodule

FILE: rtl/skt_ctrl.sv
// Controller state machine for the sorted key table.
module skt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output skt_pkg::ctrl_t ctrl_o,
  output logic          result_valid_o
);

  skt_pkg::state_e state_q, state_d;
  logic            valid_q, valid_d;

  // State and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    valid_d        = 1'b0;
    ctrl_o.capture = 1'b0;
    ctrl_o.apply   = 1'b0;
    case (state_q)
      skt_pkg::ST_IDLE: begin
        if (start) begin
          ctrl_o.capture = 1'b1;
          state_d        = skt_pkg::ST_APPLY;
        end
      end
      skt_pkg::ST_APPLY: begin
        ctrl_o.apply = 1'b1;
        valid_d      = 1'b1;
        state_d      = skt_pkg::ST_IDLE;
      end
      default: begin
        state_d = skt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q == skt_pkg::ST_APPLY);
  assign result_valid_o = valid_q;

endmodule

FILE: rtl/skt_datapath.sv
// Row of compare-and-shift key cells with count and result registers.
module skt_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  skt_pkg::ctrl_t               ctrl_i,
  input  logic [1:0]                   command_i,
  input  logic [skt_pkg::KeyW-1:0]     key_i,
  output logic                         success_o,
  output logic [skt_pkg::PosW-1:0]     position_o,
  output logic [skt_pkg::CntOutW-1:0]  entry_count_o
);

  localparam int unsigned IdxW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned EncW    = (IdxW > skt_pkg::PosW) ? IdxW : skt_pkg::PosW;
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned CntExtW = (CntW > skt_pkg::CntOutW) ? CntW : skt_pkg::CntOutW;

  logic [skt_pkg::KeyW-1:0] cell_q [CAPACITY];
  logic [skt_pkg::KeyW-1:0] key_q;
  skt_pkg::cmd_e            cmd_q;
  logic [CAPACITY-1:0]      lt_d, lt_q;
  logic [CAPACITY-1:0]      eq_d;
  logic [CAPACITY-1:0]      bound;
  logic                     found_q;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntExtW-1:0]       count_ext;
  logic [EncW-1:0]          pos_enc;
  logic                     full, ins_ok, rem_ok, srch_ok, clr;

  // Per-cell compare against the incoming key and boundary detection
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic live;
    assign live    = (CntW'(g) < count_q);
    assign lt_d[g] = live && (cell_q[g] < key_i);
    assign eq_d[g] = live && (cell_q[g] == key_i);

    if (g == 0) begin : g_first
      assign bound[g] = !lt_q[g];

      // Take the key on insert, pull the upper neighbour on remove
      always_ff @(posedge clk_i) begin
        if (ctrl_i.apply && !lt_q[g]) begin
          if (ins_ok) begin
            cell_q[g] <= key_q;
          end else if (rem_ok && (CAPACITY > 1)) begin
            cell_q[g] <= cell_q[(g + 1) % CAPACITY];
          end
        end
      end
    end else begin : g_rest
      assign bound[g] = !lt_q[g] && lt_q[g-1];

      // Take the key at the gap, otherwise shift up or down by one
      always_ff @(posedge clk_i) begin
        if (ctrl_i.apply && !lt_q[g]) begin
          if (ins_ok) begin
            cell_q[g] <= lt_q[g-1] ? key_q : cell_q[g-1];
          end else if (rem_ok && (g < CAPACITY - 1)) begin
            cell_q[g] <= cell_q[(g + 1) % CAPACITY];
          end
        end
      end
    end
  end

  // Capture the item and the compare flags
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      key_q   <= key_i;
      cmd_q   <= skt_pkg::cmd_e'(command_i);
      lt_q    <= lt_d;
      found_q <= |eq_d;
    end
  end

  // Encode the first cell not below the key
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bound[i]) begin
        pos_enc = pos_enc | EncW'(i);
      end
    end
  end

  // Decide the outcome
  assign full    = (count_q == CntW'(CAPACITY));
  assign ins_ok  = (cmd_q == skt_pkg::CMD_INSERT) && !found_q && !full;
  assign rem_ok  = (cmd_q == skt_pkg::CMD_REMOVE) && found_q;
  assign srch_ok = (cmd_q == skt_pkg::CMD_SEARCH) && found_q;
  assign clr     = (cmd_q == skt_pkg::CMD_CLEAR);

  always_comb begin
    count_d = count_q;
    if (clr) begin
      count_d = '0;
    end else if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (rem_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign count_ext = CntExtW'(count_d);

  // Count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.apply) begin
      count_q <= count_d;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      success_o     <= ins_ok || rem_ok || srch_ok || clr;
      position_o    <= (ins_ok || rem_ok || srch_ok) ? pos_enc[skt_pkg::PosW-1:0] : '0;
      entry_count_o <= count_ext[skt_pkg::CntOutW-1:0];
    end
  end

endmodule
